[design/mss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

    // Table geometry.
    localparam int MAX_SEGMENTS  = 16;
    localparam int SEG_IDX_W     = $clog2(MAX_SEGMENTS);
    localparam int SEG_CNT_W     = SEG_IDX_W + 1;
    localparam int MOTION_WORDS  = 9;
    localparam int ROW_WORDS     = 4 + MOTION_WORDS;
    localparam int DATA_W        = 32;

    // Field widths fixed by the item format.
    localparam int KIND_W        = 2;
    localparam int ENTRY_W       = 4;
    localparam int WORD_W        = 4;
    localparam int MODE_W        = 2;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [SEG_CNT_W-1:0] NONE_CODE = SEG_CNT_W'(MAX_SEGMENTS);

    // Word positions inside one table row.
    localparam logic [WORD_W-1:0] WORD_BEGIN   = 4'd0;
    localparam logic [WORD_W-1:0] WORD_END     = 4'd1;
    localparam logic [WORD_W-1:0] WORD_LIMIT   = 4'd2;
    localparam logic [WORD_W-1:0] WORD_KIND    = 4'd3;
    localparam logic [WORD_W-1:0] WORD_MOTION0 = 4'd4;
    localparam logic [WORD_W-1:0] WORD_LAST    = 4'(ROW_WORDS - 1);

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET  = 2'd2;

    // Motion modes.
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TIME  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORCE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_COUNT = 2'd1;

    typedef logic [ROW_WORDS-1:0][DATA_W-1:0]    row_t;
    typedef logic [MOTION_WORDS-1:0][DATA_W-1:0] motion_t;

    typedef struct packed {
        logic        [KIND_W-1:0]  kind;
        logic        [ENTRY_W-1:0] entry;
        logic        [WORD_W-1:0]  word;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  sample;
    } item_t;

    typedef struct packed {
        logic        [SEG_CNT_W-1:0] active_segment;
        logic signed [DATA_W-1:0]    vel_x;
        logic signed [DATA_W-1:0]    vel_y;
        logic signed [DATA_W-1:0]    vel_z;
        logic signed [DATA_W-1:0]    spin_x;
        logic signed [DATA_W-1:0]    spin_y;
        logic signed [DATA_W-1:0]    spin_z;
        logic signed [DATA_W-1:0]    pivot_x;
        logic signed [DATA_W-1:0]    pivot_y;
        logic signed [DATA_W-1:0]    pivot_z;
    } result_t;

    // Write request into the segment table.
    typedef struct packed {
        logic                 en;
        logic [SEG_IDX_W-1:0] addr;
        logic [WORD_W-1:0]    word;
        logic [DATA_W-1:0]    data;
    } mem_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FORCE,
        ST_LOAD
    } state_t;

endpackage

`default_nettype wire

[design/mss_seg_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

// Segment table: one row per segment, written one word at a time and read
// a whole row at a time through a registered read port.
module mss_seg_mem
    import mss_pkg::*;
(
    input  wire logic                 clk,
    input  wire mem_wr_t              wr,
    input  wire logic [SEG_IDX_W-1:0] rd_addr,
    output      row_t                 rd_data
);

    row_t mem [MAX_SEGMENTS];
    row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr][wr.word] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/mss_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Item sequencer: takes items, walks the segment table through its single
// read port and holds the current segment and motion.
module mss_sequencer
    import mss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire item_t                item,
    input  wire logic [MODE_W-1:0]    motion_mode,
    input  wire logic [SEG_CNT_W-1:0] live_count,
    output      logic                 busy,
    output      logic                 result_valid,
    output      result_t              result,
    output      mem_wr_t              mem_wr,
    output      logic [SEG_IDX_W-1:0] mem_rd_addr,
    input  wire row_t                 mem_rd_data
);

    state_t                    state_reg, state_next;
    logic [SEG_IDX_W-1:0]      idx_reg, idx_next;
    logic [SEG_CNT_W-1:0]      cur_reg, cur_next;
    logic                      chosen_reg, chosen_next;
    logic                      init_reg, init_next;
    logic                      done_reg, done_next;
    logic signed [DATA_W-1:0]  sample_reg, sample_next;
    motion_t                   motion_reg, motion_next;

    logic                 accept;
    logic [SEG_CNT_W-1:0] scan_first;
    logic [SEG_CNT_W-1:0] idx_inc;
    logic                 time_go;
    logic                 force_go;
    logic                 scan_hit;
    logic                 scan_more;
    logic                 force_step;
    logic                 force_load;
    motion_t              row_motion;

    assign accept     = start && (state_reg == ST_IDLE);
    assign scan_first = chosen_reg ? cur_reg : '0;
    assign idx_inc    = SEG_CNT_W'(idx_reg) + SEG_CNT_W'(1);
    assign row_motion = mem_rd_data[ROW_WORDS-1:WORD_MOTION0];

    // An update that needs the table at all.
    assign time_go  = accept && (item.kind == KIND_UPDATE) && (motion_mode == MODE_TIME)
                      && (scan_first < live_count);
    assign force_go = accept && (item.kind == KIND_UPDATE) && (motion_mode == MODE_FORCE)
                      && (chosen_reg ? (cur_reg < live_count) : (live_count != '0));

    assign scan_hit  = ($signed(mem_rd_data[WORD_BEGIN]) <= sample_reg)
                       && (sample_reg <= $signed(mem_rd_data[WORD_END]));
    assign scan_more = idx_inc < live_count;

    assign force_step = mem_rd_data[WORD_KIND][0]
                        ? (sample_reg > $signed(mem_rd_data[WORD_LIMIT]))
                        : (sample_reg < $signed(mem_rd_data[WORD_LIMIT]));
    assign force_load = force_step && scan_more;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (time_go)
                begin
                    state_next = ST_SCAN;
                end
                else if (force_go)
                begin
                    state_next = ST_FORCE;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || !scan_more)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FORCE:
            begin
                state_next = force_load ? ST_LOAD : ST_IDLE;
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next    = idx_reg;
        cur_next    = cur_reg;
        chosen_next = chosen_reg;
        init_next   = init_reg;
        sample_next = sample_reg;
        motion_next = motion_reg;
        done_next   = 1'b0;
        mem_rd_addr = idx_reg;
        mem_wr      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sample_next = item.sample;
                    done_next   = !(time_go || force_go);
                    case (item.kind)
                        KIND_WRITE:
                        begin
                            mem_wr.en   = (SEG_CNT_W'(item.entry) < live_count)
                                          && (item.word <= WORD_LAST);
                            mem_wr.addr = SEG_IDX_W'(item.entry);
                            mem_wr.word = item.word;
                            mem_wr.data = item.value;
                        end
                        KIND_UPDATE:
                        begin
                            case (motion_mode)
                                MODE_TIME:
                                begin
                                    if (time_go)
                                    begin
                                        idx_next    = scan_first[SEG_IDX_W-1:0];
                                        mem_rd_addr = scan_first[SEG_IDX_W-1:0];
                                    end
                                    else
                                    begin
                                        motion_next = '0;
                                    end
                                end
                                MODE_FORCE:
                                begin
                                    if (!chosen_reg)
                                    begin
                                        chosen_next = 1'b1;
                                        cur_next    = '0;
                                    end
                                    init_next = !chosen_reg;
                                    if (force_go)
                                    begin
                                        idx_next    = scan_first[SEG_IDX_W-1:0];
                                        mem_rd_addr = scan_first[SEG_IDX_W-1:0];
                                    end
                                    else
                                    begin
                                        motion_next = '0;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        KIND_RESET:
                        begin
                            chosen_next = 1'b0;
                            cur_next    = '0;
                            motion_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    done_next = 1'b1;
                    if (!chosen_reg || (cur_reg != SEG_CNT_W'(idx_reg)))
                    begin
                        cur_next    = SEG_CNT_W'(idx_reg);
                        chosen_next = 1'b1;
                        motion_next = row_motion;
                    end
                end
                else if (scan_more)
                begin
                    idx_next    = idx_inc[SEG_IDX_W-1:0];
                    mem_rd_addr = idx_inc[SEG_IDX_W-1:0];
                end
                else
                begin
                    done_next   = 1'b1;
                    motion_next = '0;
                end
            end
            ST_FORCE:
            begin
                if (!force_step)
                begin
                    done_next = 1'b1;
                    if (init_reg)
                    begin
                        motion_next = row_motion;
                    end
                end
                else
                begin
                    cur_next = idx_inc;
                    if (scan_more)
                    begin
                        idx_next    = idx_inc[SEG_IDX_W-1:0];
                        mem_rd_addr = idx_inc[SEG_IDX_W-1:0];
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        motion_next = '0;
                    end
                end
            end
            ST_LOAD:
            begin
                done_next   = 1'b1;
                motion_next = row_motion;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            cur_reg    <= '0;
            chosen_reg <= 1'b0;
            init_reg   <= 1'b0;
            done_reg   <= 1'b0;
            motion_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            cur_reg    <= cur_next;
            chosen_reg <= chosen_next;
            init_reg   <= init_next;
            done_reg   <= done_next;
            motion_reg <= motion_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = done_reg;

    always_comb
    begin
        result.active_segment = chosen_reg ? cur_reg : NONE_CODE;
        result.vel_x          = motion_reg[0];
        result.vel_y          = motion_reg[1];
        result.vel_z          = motion_reg[2];
        result.spin_x         = motion_reg[3];
        result.spin_y         = motion_reg[4];
        result.spin_z         = motion_reg[5];
        result.pivot_x        = motion_reg[6];
        result.pivot_y        = motion_reg[7];
        result.pivot_z        = motion_reg[8];
    end

endmodule

`default_nettype wire

[design/motion_segment_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Motion segment sequencer. An item is taken when start is high and busy is
// low, and every item produces exactly one result transaction: result_valid
// is high for one cycle and the receiver must take the result then, since
// the block cannot hold it. Table writes, segment resets and updates that do
// not touch the table (no motion mode, nothing left to search) strobe the
// result in the cycle after the item. A time update reads one table row per
// cycle starting at the current segment, or at row 0 when none is selected,
// and examines at most as many rows as the segment count. A force update
// reads the current segment's row in ST_FORCE, and a further row in ST_LOAD
// when it advances to a segment whose motion must be loaded. The single read
// port of the segment table returns one whole row per cycle. Configuration
// is taken at any time through cfg_valid and cfg_ready, but should only be
// written while the block is idle.
module motion_segment_sequencer
    import mss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output      logic                   busy,
    input  wire item_t                  item,
    output      logic                   result_valid,
    output      result_t                result,
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]      cfg_data
);

    logic [MODE_W-1:0]    mode_reg;
    logic [SEG_CNT_W-1:0] count_reg;
    logic [SEG_CNT_W-1:0] live_count;
    mem_wr_t              mem_wr;
    logic [SEG_IDX_W-1:0] mem_rd_addr;
    row_t                 mem_rd_data;

    // The configuration channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NONE;
            count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MOTION_MODE:
                begin
                    mode_reg <= cfg_data[MODE_W-1:0];
                end
                CFG_SEGMENT_COUNT:
                begin
                    count_reg <= cfg_data[SEG_CNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The segment count may exceed the table size; only the table's rows count.
    assign live_count = (count_reg > NONE_CODE) ? NONE_CODE : count_reg;

    // A table write lands at the edge that takes the item, and the earliest
    // read of the same row is issued at a later edge, so no forwarding is needed.
    mss_seg_mem u_seg_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    mss_sequencer u_sequencer (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .motion_mode  (mode_reg),
        .live_count   (live_count),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .mem_wr       (mem_wr),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    // A result is only strobed once the item's work is finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobed while an item is still in progress");

    // Items that do not update answer in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.kind != KIND_UPDATE)) |=> result_valid)
        else $error("non-update item did not produce its result");

    // With no segment selected, or past the end of the table, motion is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.active_segment == NONE_CODE)) |->
        ((result.vel_x == '0) && (result.vel_y == '0) && (result.vel_z == '0)
         && (result.spin_x == '0) && (result.spin_y == '0) && (result.spin_z == '0)
         && (result.pivot_x == '0) && (result.pivot_y == '0) && (result.pivot_z == '0)))
        else $error("motion reported without a selected segment");

    // An item taken while idle makes the block busy or answers next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || result_valid))
        else $error("accepted item was lost");

endmodule

`default_nettype wire
